>>> rtl/lir_pkg.sv
// Package for the linear interpolation resampler.
// Holds widths, phase constants, register indexes and shared types.
// No dependencies.
`default_nettype none

package lir_pkg;

    localparam int MAX_CHANNELS = 4;
    localparam int NUM_LANES    = 4;
    localparam int FRAC_BITS    = 16;
    localparam int SAMPLE_W     = 16;
    localparam int PHASE_W      = FRAC_BITS + 5;
    localparam int CFG_DATA_W   = 21;
    localparam int CH_W         = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int DIFF_W       = SAMPLE_W + 1;
    localparam int PROD_W       = DIFF_W + FRAC_BITS + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
    localparam logic [PHASE_W-1:0] PHASE_TWO = PHASE_W'(1) << (FRAC_BITS + 1);
    localparam logic [PHASE_W-1:0] STEP_MIN  = PHASE_ONE >> 4;
    localparam logic [PHASE_W-1:0] STEP_MAX  = PHASE_ONE << 4;

    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 1'b1;

    localparam logic [CFG_DATA_W-1:0] PHASE_STEP_RESET = CFG_DATA_W'(65536);
    localparam logic [CH_W-1:0]       CHANNELS_RESET   = CH_W'(2);

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic            load;
        logic            last;
        logic [CH_W-1:0] active;
    } merge_ctrl_t;

endpackage

`default_nettype wire

>>> rtl/linear_interp_resampler.sv
// Linear interpolation sample rate converter, top level.
// Sequencer, configuration registers, four lir_lane lanes and lir_merge.
// Depends on lir_pkg, lir_lane, lir_merge.
//
// Usage:
//   Input channel (s_*): one frame of four signed 16-bit samples plus
//   s_final_frame per transfer. Output channel (m_*): one interpolated frame
//   per transfer, m_last_out on the final frame of a stream.
//   Config: cfg_we/cfg_index/cfg_wdata, index 0 phase_step (Q5.16),
//   index 1 channels_in_use. Write only while the block is idle.
//   One frame is processed at a time. Each result passes the product
//   register, then the output register load; an input frame adds
//   sequencing (accept, phase wrap) and a final frame a tail step. A
//   frame that yields no result only takes accept and phase wrap, a
//   non-final first frame of a stream only the accept. s_ready rises after
//   the phase wrap that follows the load of the last result of the frame
//   into the output register (and the tail step when a final frame ends
//   on an interpolated result), so the next frame is taken while it waits.
//   If m_ready is low the sequencer holds its next result until the output
//   register frees. Reset clears phase, history and restores the default
//   registers (step 1.0, two channels).
`default_nettype none

module linear_interp_resampler
    import lir_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire sample_t               s_in_ch0,
    input  wire sample_t               s_in_ch1,
    input  wire sample_t               s_in_ch2,
    input  wire sample_t               s_in_ch3,
    input  wire logic                  s_final_frame,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output sample_t                    m_out_ch0,
    output sample_t                    m_out_ch1,
    output sample_t                    m_out_ch2,
    output sample_t                    m_out_ch3,
    output logic                       m_last_out
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_TAIL,
        ST_PUSH
    } state_t;

    state_t                  state_reg;
    logic                    tail_ret_reg;
    logic                    final_reg;
    logic                    have_prev_reg;
    logic [PHASE_W-1:0]      phase_reg;
    logic [CFG_DATA_W-1:0]   phase_step_reg;
    logic [CH_W-1:0]         channels_reg;
    sample_t                 prev_reg [NUM_LANES];
    sample_t                 cur_reg  [NUM_LANES];
    sample_t                 in_frame [NUM_LANES];
    sample_t                 lane_res [NUM_LANES];
    sample_t                 out_frame [NUM_LANES];

    logic [PHASE_W-1:0]      step_raw;
    logic [PHASE_W-1:0]      step_eff;
    logic [CH_W-1:0]         chan_eff;
    logic [PHASE_W-1:0]      phase_sum;
    logic                    phase_low;
    logic                    accept;
    logic                    mul_en;
    logic                    out_free;
    logic                    push_last;
    merge_ctrl_t             mctrl;

    assign in_frame[0] = s_in_ch0;
    assign in_frame[1] = s_in_ch1;
    assign in_frame[2] = s_in_ch2;
    assign in_frame[3] = s_in_ch3;

    // Clamped configuration
    assign step_raw = PHASE_W'(phase_step_reg);
    always_comb begin
        if (step_raw < STEP_MIN) begin
            step_eff = STEP_MIN;
        end else if (step_raw > STEP_MAX) begin
            step_eff = STEP_MAX;
        end else begin
            step_eff = step_raw;
        end
        if (channels_reg == CH_W'(0)) begin
            chan_eff = CH_W'(1);
        end else if (channels_reg > CH_W'(MAX_CHANNELS)) begin
            chan_eff = CH_W'(MAX_CHANNELS);
        end else begin
            chan_eff = channels_reg;
        end
        if (chan_eff > CH_W'(NUM_LANES)) begin
            chan_eff = CH_W'(NUM_LANES);
        end
    end

    assign phase_sum = phase_reg + step_eff;
    assign phase_low = phase_reg < PHASE_ONE;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign mul_en    = ((state_reg == ST_INTERP) || (state_reg == ST_TAIL)) && phase_low;

    // Interp result of a final frame is last when no tail position follows; tail result when phase wraps
    assign push_last = tail_ret_reg ? (phase_sum >= PHASE_ONE)
                                    : (final_reg && (phase_sum >= PHASE_TWO));

    assign mctrl.load   = (state_reg == ST_PUSH) && out_free;
    assign mctrl.last   = push_last;
    assign mctrl.active = chan_eff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_step_reg <= PHASE_STEP_RESET;
            channels_reg   <= CHANNELS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PHASE_STEP: phase_step_reg <= cfg_wdata;
                CFG_CHANNELS:   channels_reg   <= cfg_wdata[CH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tail_ret_reg  <= 1'b0;
            final_reg     <= 1'b0;
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            for (int j = 0; j < NUM_LANES; j++) begin
                prev_reg[j] <= sample_t'(0);
            end
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        final_reg <= s_final_frame;
                        cur_reg   <= in_frame;
                        if (have_prev_reg) begin
                            state_reg <= ST_INTERP;
                        end else begin
                            prev_reg      <= in_frame;
                            have_prev_reg <= 1'b1;
                            state_reg     <= s_final_frame ? ST_TAIL : ST_IDLE;
                        end
                    end
                end
                ST_INTERP: begin
                    if (phase_low) begin
                        tail_ret_reg <= 1'b0;
                        state_reg    <= ST_PUSH;
                    end else begin
                        phase_reg <= phase_reg - PHASE_ONE;
                        prev_reg  <= cur_reg;
                        state_reg <= final_reg ? ST_TAIL : ST_IDLE;
                    end
                end
                ST_TAIL: begin
                    if (phase_low) begin
                        tail_ret_reg <= 1'b1;
                        state_reg    <= ST_PUSH;
                    end else begin
                        phase_reg     <= '0;
                        have_prev_reg <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                ST_PUSH: begin
                    if (out_free) begin
                        phase_reg <= phase_sum;
                        state_reg <= tail_ret_reg ? ST_TAIL : ST_INTERP;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lir_lane u_lane (
            .aclk   (aclk),
            .mul_en (mul_en),
            .prev   (prev_reg[g]),
            .cur    (cur_reg[g]),
            .frac   (phase_reg[FRAC_BITS-1:0]),
            .result (lane_res[g])
        );
    end

    lir_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (mctrl),
        .lane_res (lane_res),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_out    (out_frame),
        .m_last   (m_last_out)
    );

    assign m_out_ch0 = out_frame[0];
    assign m_out_ch1 = out_frame[1];
    assign m_out_ch2 = out_frame[2];
    assign m_out_ch3 = out_frame[3];

    // Results are only produced from a phase inside the current interval
    a_push_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PUSH) |-> phase_low)
        else $error("result issued with phase at or above one");

    // A stream's first frame, if not final, is stored without producing output
    a_first_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !have_prev_reg && !s_final_frame) |=> (have_prev_reg && !m_valid)
            || (have_prev_reg && $stable(m_valid)))
        else $error("first frame not stored as history");

    // Lane 3 reads zero while it is inactive
    a_lane_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (chan_eff < CH_W'(4)) && $stable(chan_eff)
            && !$past(mctrl.load && (mctrl.active != chan_eff))) |-> (m_out_ch3 == 16'sd0))
        else $error("inactive lane carries data");

endmodule

`default_nettype wire

>>> rtl/lir_lane.sv
// One interpolation lane: prev + frac*(cur-prev), rounded half up.
// Product is registered; rounding and add follow the register. Uses lir_pkg.
`default_nettype none

module lir_lane
    import lir_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 mul_en,
    input  wire sample_t              prev,
    input  wire sample_t              cur,
    input  wire logic [FRAC_BITS-1:0] frac,
    output sample_t                   result
);

    logic signed [DIFF_W-1:0]   diff;
    logic signed [FRAC_BITS:0]  frac_s;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    sample_t                    base_reg;
    logic signed [PROD_W-1:0]   rounded;
    logic signed [PROD_W-1:0]   shifted;

    assign diff      = DIFF_W'(cur) - DIFF_W'(prev);
    assign frac_s    = $signed({1'b0, frac});
    assign prod_next = PROD_W'(diff) * PROD_W'(frac_s);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
            base_reg <= prev;
        end
    end

    assign rounded = prod_reg + (PROD_W'(1) <<< (FRAC_BITS - 1));
    assign shifted = rounded >>> FRAC_BITS;
    assign result  = base_reg + sample_t'(shifted[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

>>> rtl/lir_merge.sv
// Merging stage: gathers lane results into the output register,
// zeroes inactive lanes and carries the end-of-stream mark. Uses lir_pkg.
`default_nettype none

module lir_merge
    import lir_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire merge_ctrl_t ctrl,
    input  wire sample_t     lane_res [NUM_LANES],
    output logic             out_free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output sample_t          m_out [NUM_LANES],
    output logic             m_last
);

    logic valid_reg;
    logic last_reg;
    sample_t data_reg [NUM_LANES];

    assign out_free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctrl.load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            last_reg <= ctrl.last;
            for (int j = 0; j < NUM_LANES; j++) begin
                data_reg[j] <= (CH_W'(j) < ctrl.active) ? lane_res[j] : sample_t'(0);
            end
        end
    end

    assign m_valid = valid_reg;
    assign m_last  = last_reg;
    assign m_out   = data_reg;

endmodule

`default_nettype wire

>>> dv/linear_interp_resampler_tb.sv
// Testbench for linear_interp_resampler: streams audio frames under random
// pacing and backpressure, predicts each interpolated output frame and checks it.
// Depends on lir_pkg and the linear_interp_resampler RTL.

class resample_scoreboard;
    typedef struct packed {
        logic                   last;
        logic [3:0][15:0]       lane;
    } out_frame_t;

    localparam longint ONE = longint'(1) << lir_pkg::FRAC_BITS;

    logic [lir_pkg::CFG_DATA_W-1:0] step_reg;
    logic [lir_pkg::CH_W-1:0]       chans_reg;
    int                             prev_lane [4];
    bit                             have_prev;
    longint                         phase;
    out_frame_t                     expected_q [$];
    int                             errors;

    function new();
        step_reg  = lir_pkg::PHASE_STEP_RESET;
        chans_reg = lir_pkg::CHANNELS_RESET;
        foreach (prev_lane[j]) prev_lane[j] = 0;
        have_prev = 0;
        phase     = 0;
        errors    = 0;
    endfunction

    function void write_reg(logic [lir_pkg::CFG_IDX_W-1:0] idx,
                            logic [lir_pkg::CFG_DATA_W-1:0] data);
        if (idx == lir_pkg::CFG_PHASE_STEP) begin
            step_reg = data;
        end else if (idx == lir_pkg::CFG_CHANNELS) begin
            chans_reg = data[lir_pkg::CH_W-1:0];
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // round to nearest, ties toward +inf
    function int blend(int a, int b, longint frac);
        longint p;
        p = (longint'(b) - longint'(a)) * frac + (ONE >>> 1);
        return a + int'(p >>> lir_pkg::FRAC_BITS);
    endfunction

    function out_frame_t make_frame(input int v [4], int active);
        out_frame_t f;
        f.last = 1'b0;
        for (int j = 0; j < 4; j++) begin
            f.lane[j] = (j < active) ? 16'(v[j]) : 16'h0000;
        end
        return f;
    endfunction

    function void note_input(logic [3:0][15:0] smp, logic fin);
        longint     step;
        int         active;
        int         cur [4];
        int         mix [4];
        int         n;
        out_frame_t batch [32];

        step   = longint'(step_reg);
        if (step < longint'(lir_pkg::STEP_MIN)) step = longint'(lir_pkg::STEP_MIN);
        if (step > longint'(lir_pkg::STEP_MAX)) step = longint'(lir_pkg::STEP_MAX);
        active = int'(chans_reg);
        if (active < 1) active = 1;
        if (active > lir_pkg::MAX_CHANNELS) active = lir_pkg::MAX_CHANNELS;
        if (active > lir_pkg::NUM_LANES) active = lir_pkg::NUM_LANES;
        for (int j = 0; j < 4; j++) cur[j] = int'($signed(smp[j]));
        n = 0;

        if (have_prev) begin
            while (phase < ONE && n < 32) begin
                for (int j = 0; j < 4; j++) mix[j] = blend(prev_lane[j], cur[j], phase);
                batch[n] = make_frame(mix, active);
                n++;
                phase += step;
            end
            phase = (phase >= ONE) ? phase - ONE : 0;
        end
        prev_lane = cur;
        have_prev = 1;

        if (fin) begin
            // positions past the end repeat the last frame
            while (phase < ONE && n < 32) begin
                batch[n] = make_frame(cur, active);
                n++;
                phase += step;
            end
            if (n > 0) batch[n-1].last = 1'b1;
            have_prev = 0;
            phase     = 0;
        end
        for (int k = 0; k < n; k++) expected_q.push_back(batch[k]);
    endfunction

    task report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        errors++;
    endtask

    task check_result(out_frame_t got);
        out_frame_t exp_f;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("output transfer with nothing pending: %h", got));
            return;
        end
        exp_f = expected_q.pop_front();
        for (int j = 0; j < 4; j++) begin
            if (got.lane[j] !== exp_f.lane[j]) begin
                report_mismatch($sformatf("out_ch%0d: expected %0d, got %0d", j,
                    $signed(exp_f.lane[j]), $signed(got.lane[j])));
            end
        end
        if (got.last !== exp_f.last) begin
            report_mismatch($sformatf("last_out: expected %0b, got %0b",
                exp_f.last, got.last));
        end
    endtask
endclass

module linear_interp_resampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lir_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE         = 10;

    typedef enum int {RX_STREAM, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = CFG_PHASE_STEP;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    sample_t               s_in_ch0      = '0;
    sample_t               s_in_ch1      = '0;
    sample_t               s_in_ch2      = '0;
    sample_t               s_in_ch3      = '0;
    logic                  s_final_frame = 1'b0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    sample_t               m_out_ch0;
    sample_t               m_out_ch1;
    sample_t               m_out_ch2;
    sample_t               m_out_ch3;
    logic                  m_last_out;

    resample_scoreboard sb = new();

    int idle_cycles    = 0;
    int burst_left     = 0;
    bit pace_on        = 1'b1;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    linear_interp_resampler DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_ch0      (s_in_ch0),
        .s_in_ch1      (s_in_ch1),
        .s_in_ch2      (s_in_ch2),
        .s_in_ch3      (s_in_ch3),
        .s_final_frame (s_final_frame),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_ch0     (m_out_ch0),
        .m_out_ch1     (m_out_ch1),
        .m_out_ch2     (m_out_ch2),
        .m_out_ch3     (m_out_ch3),
        .m_last_out    (m_last_out)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // monitor, register mirror and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_we) sb.write_reg(cfg_index, cfg_wdata);
            if (m_valid && m_ready) begin
                sb.check_result({m_last_out, m_out_ch3, m_out_ch2, m_out_ch1, m_out_ch0});
            end
            if (s_valid && s_ready) begin
                sb.note_input({s_in_ch3, s_in_ch2, s_in_ch1, s_in_ch0}, s_final_frame);
            end
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // receiver backpressure
    initial begin
        rx_mode_t mode;
        int       mode_left;
        mode      = RX_STREAM;
        mode_left = 0;
        forever begin
            @(posedge aclk);
            if (long_hold_req && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                case (mode)
                    RX_STREAM: m_ready <= 1'b1;
                    RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                    RX_MOSTLY: m_ready <= ($urandom_range(0, 4) != 0);
                    default:   m_ready <= ($urandom_range(0, 4) == 0);
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_rate(logic [CFG_DATA_W-1:0] step, logic [CH_W-1:0] chans);
        write_reg(CFG_PHASE_STEP, step);
        write_reg(CFG_CHANNELS, CFG_DATA_W'(chans));
    endtask

    task automatic send_frame(sample_t c0, sample_t c1, sample_t c2, sample_t c3,
                              logic fin);
        int gap;
        s_in_ch0      <= c0;
        s_in_ch1      <= c1;
        s_in_ch2      <= c2;
        s_in_ch3      <= c3;
        s_final_frame <= fin;
        s_valid       <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        if (pace_on) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 10);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
        end
    endtask

    // let the monitor note the last accepted frame before polling the scoreboard
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return sample_t'($urandom_range(0, 64)) - 16'sd32;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_step();
        case ($urandom_range(0, 7))
            0:       return CFG_DATA_W'($urandom_range(0, 4095));
            1:       return CFG_DATA_W'($urandom_range(1048577, 2097151));
            2, 3:    return CFG_DATA_W'($urandom_range(4096, 65536));
            4:       return CFG_DATA_W'($urandom_range(60000, 70000));
            default: return CFG_DATA_W'($urandom_range(65536, 1048576));
        endcase
    endfunction

    initial begin
        int n_items;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // defaults: unit step, two channels
        send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd100, -16'sd100, 16'sd5, -16'sd5, 1'b1);
        drain();

        // step below range, all lanes: full 16x upsample then final tail
        set_rate(21'd4095, 3'd4);
        send_frame(16'sd1, -16'sd1, 16'sd0, 16'sh7fff, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, -16'sd1, 16'sd0, 1'b1);
        drain();

        // final frame as the first frame of a stream
        set_rate(21'd0, 3'd0);
        send_frame(16'sh1234, 16'sh8000, 16'sh7fff, -16'sd7, 1'b1);
        drain();

        // step above range: frames that yield nothing, final with no mark
        set_rate(21'h1fffff, 3'd7);
        send_frame(16'sd10, 16'sd20, 16'sd30, 16'sd40, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_frame(16'sd1, 16'sd2, 16'sd3, 16'sd4, 1'b0);
        send_frame(-16'sd1, -16'sd2, -16'sd3, -16'sd4, 1'b1);
        drain();

        // half step: rounding ties
        set_rate(21'd32768, 3'd4);
        send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        send_frame(16'sd1, -16'sd1, 16'sd3, -16'sd3, 1'b0);
        send_frame(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1);
        drain();

        // largest legal step, then an odd step with three lanes
        set_rate(21'd1048576, 3'd4);
        send_frame(16'sd9, 16'sd8, 16'sd7, 16'sd6, 1'b0);
        send_frame(16'sd90, 16'sd80, 16'sd70, 16'sd60, 1'b1);
        drain();
        set_rate(21'd65537, 3'd3);
        send_frame(16'sd3, 16'sd2, 16'sd1, 16'sd0, 1'b0);
        send_frame(16'sh7fff, 16'sh8000, 16'sd0, 16'sh7fff, 1'b0);
        send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            if ($urandom_range(0, 1) == 0) begin
                set_rate(rand_step(), CH_W'($urandom_range(0, 7)));
            end else begin
                write_reg(CFG_PHASE_STEP, rand_step());
            end
            pace_on = (ph % 4 != 3);
            if (ph == 2) long_hold_req = 1'b1;
            n_items = $urandom_range(12, 22);
            for (int i = 0; i < n_items; i++) begin
                send_frame(rand_sample(), rand_sample(), rand_sample(), rand_sample(),
                           ($urandom_range(0, 9) == 0) || (i == n_items - 1 && ph == 8));
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/lir_pkg.sv
rtl/lir_lane.sv
rtl/lir_merge.sv
rtl/linear_interp_resampler.sv
dv/linear_interp_resampler_tb.sv
